// ===== hw/rtl/lexeme_token_classifier_defines.svh =====
// Assertion macros shared by the lexeme classifier RTL.
// Needs a clock named clk and an active-low reset named rst_n in scope.
`ifndef LEXEME_TOKEN_CLASSIFIER_DEFINES_SVH
`define LEXEME_TOKEN_CLASSIFIER_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define LTC_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define LTC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/ltc_pkg.sv =====
// Shared types, class codes and keyword table for the lexeme classifier.
// No dependencies.
package ltc_pkg;

    localparam int TABLE_SIZE = 20;

    typedef logic [4:0]            token_class_t;
    typedef logic [TABLE_SIZE-1:0] kw_vec_t;
    typedef logic [2:0]            pos_t;

    localparam token_class_t CLASS_LITERAL    = 5'd20;
    localparam token_class_t CLASS_NUMBER     = 5'd21;
    localparam token_class_t CLASS_IDENTIFIER = 5'd22;
    localparam token_class_t CLASS_INVALID    = 5'd23;

    localparam logic [7:0] QUOTE_BYTE = 8'h22;

    // Keyword and operator spellings, padded with zero to eight bytes.
    localparam logic [7:0] KW_TEXT [TABLE_SIZE][8] = '{
        '{"i", "f", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"w", "h", "i", "l", "e", 8'h00, 8'h00, 8'h00},
        '{"i", "n", "t", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"r", "e", "t", "u", "r", "n", 8'h00, 8'h00},
        '{"+", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"-", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"*", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"/", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{">", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"&", "&", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"|", "|", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"=", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"=", "=", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"!", "=", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"!", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"(", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{")", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"{", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"}", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{";", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}
    };

    localparam logic [2:0] KW_LEN [TABLE_SIZE] = '{
        3'd2, 3'd5, 3'd3, 3'd6, 3'd1, 3'd1, 3'd1, 3'd1, 3'd1, 3'd2,
        3'd2, 3'd1, 3'd2, 3'd2, 3'd1, 3'd1, 3'd1, 3'd1, 3'd1, 3'd1
    };

    // Summary of one finished lexeme, handed from front to back.
    typedef struct packed {
        logic    quoted;     // first byte was a double quote
        logic    end_quote;  // last byte was a double quote
        logic    valid;      // every byte allowed
        logic    digits;     // every byte a digit
        kw_vec_t hit;        // table entries matched at exact length
    } ltc_rec_t;

endpackage

// ===== hw/rtl/lexeme_token_classifier.sv =====
// Top level of the lexeme token classifier.
// Depends on ltc_pkg, ltc_front, ltc_queue and ltc_back.
//
// Takes a lexeme one byte per beat (is_last on its final byte) and returns one
// token class per lexeme: keywords if/while/int/return and sixteen operators
// as 0 to 19 in table order, then literal (20), number (21), identifier (22)
// and invalid (23). A lexeme opening with a double quote is a literal when its
// last byte is also a double quote (a lone quote byte counts), and its inner
// bytes go unchecked. Input runs at one byte per clock while full is low, with
// no gap needed between lexemes. The front keeps the running scan state and,
// on the last byte, writes a short summary into a small queue (QUEUE_DEPTH
// entries); the back turns the oldest summary into a class and holds it in an
// output register. A class reaches the result side through the queue and then
// the output register. full rises only when the queue and the output register
// all hold lexemes that nobody has popped, so input stalls come only from a
// stalled result side.
module lexeme_token_classifier
    import ltc_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    output logic         full,
    input  logic [7:0]   char_in,
    input  logic         is_last,
    output logic         empty,
    input  logic         pop,
    output token_class_t token_class
);

    logic     accept;
    logic     rec_valid;
    ltc_rec_t rec;
    logic     q_full;
    logic     q_not_empty;
    ltc_rec_t q_data;
    logic     q_take;
    logic     out_valid;

    // Beats are taken whenever the queue has room, last byte or not.
    assign accept = push && !q_full;
    assign full   = q_full;
    assign empty  = !out_valid;

    ltc_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .char_in   (char_in),
        .is_last   (is_last),
        .rec_valid (rec_valid),
        .rec       (rec)
    );

    ltc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr        (rec_valid),
        .wr_data   (rec),
        .rd        (q_take),
        .full      (q_full),
        .not_empty (q_not_empty),
        .rd_data   (q_data)
    );

    ltc_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (q_not_empty),
        .in_rec      (q_data),
        .in_take     (q_take),
        .pop         (pop),
        .out_valid   (out_valid),
        .token_class (token_class)
    );

endmodule

// ===== hw/rtl/ltc_front.sv =====
// Front end: per-byte scan state and lexeme summary on the last byte.
// Depends on ltc_pkg.
module ltc_front
    import ltc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       accept,
    input  logic [7:0] char_in,
    input  logic       is_last,
    output logic       rec_valid,
    output ltc_rec_t   rec
);

    pos_t    pos_reg;
    logic    quote_reg;
    logic    valid_reg;
    logic    digits_reg;
    kw_vec_t match_reg;

    logic    quoted;
    logic    byte_digit;
    logic    byte_allowed;
    kw_vec_t match;
    kw_vec_t hit;

    always_comb
    begin
        byte_digit = (char_in >= "0") && (char_in <= "9");
        byte_allowed = byte_digit
            || ((char_in >= "a") && (char_in <= "z"))
            || ((char_in >= "A") && (char_in <= "Z"));
        case (char_in)
            "(", ")", "{", "}", ",", ";", "=", "|",
            "&", "!", "+", "*", "\"", ">", "/", "-": byte_allowed = 1'b1;
            default: ;
        endcase
    end

    assign quoted = (pos_reg == 3'd0) ? (char_in == QUOTE_BYTE) : quote_reg;

    always_comb
    begin
        for (int k = 0; k < TABLE_SIZE; k++)
        begin
            match[k] = match_reg[k] && (pos_reg < KW_LEN[k])
                       && (KW_TEXT[k][pos_reg] == char_in);
            hit[k]   = match[k] && (({1'b0, pos_reg} + 4'd1) == {1'b0, KW_LEN[k]});
        end
    end

    assign rec_valid     = accept && is_last;
    assign rec.quoted    = quoted;
    assign rec.end_quote = (char_in == QUOTE_BYTE);
    assign rec.valid     = valid_reg && byte_allowed;
    assign rec.digits    = digits_reg && byte_digit;
    assign rec.hit       = hit;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg    <= '0;
            quote_reg  <= 1'b0;
            valid_reg  <= 1'b1;
            digits_reg <= 1'b1;
            match_reg  <= '1;
        end
        else if (accept)
        begin
            if (is_last)
            begin
                pos_reg    <= '0;
                quote_reg  <= 1'b0;
                valid_reg  <= 1'b1;
                digits_reg <= 1'b1;
                match_reg  <= '1;
            end
            else
            begin
                pos_reg    <= (pos_reg == 3'd7) ? pos_reg : pos_reg + 3'd1;
                quote_reg  <= quoted;
                valid_reg  <= rec.valid;
                digits_reg <= rec.digits;
                match_reg  <= match;
            end
        end
    end

endmodule

// ===== hw/rtl/ltc_queue.sv =====
// Short queue of lexeme summaries between front and back.
// Depends on ltc_pkg and the assertion macro header.
`include "lexeme_token_classifier_defines.svh"
module ltc_queue
    import ltc_pkg::*;
#(
    parameter int DEPTH = 2
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     wr,
    input  ltc_rec_t wr_data,
    input  logic     rd,
    output logic     full,
    output logic     not_empty,
    output ltc_rec_t rd_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    ltc_rec_t           store_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [CNT_W-1:0]   count_reg;
    logic               do_wr;
    logic               do_rd;

    assign full      = (count_reg == CNT_W'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign rd_data   = store_reg[rd_ptr_reg];
    assign do_wr     = wr && !full;
    assign do_rd     = rd && not_empty;

    always_ff @(posedge clk)
    begin
        if (do_wr)
            store_reg[wr_ptr_reg] <= wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_wr)
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0
                              : wr_ptr_reg + PTR_W'(1);
            if (do_rd)
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0
                              : rd_ptr_reg + PTR_W'(1);
            if (do_wr && !do_rd)
                count_reg <= count_reg + CNT_W'(1);
            else if (do_rd && !do_wr)
                count_reg <= count_reg - CNT_W'(1);
        end
    end

    `LTC_ASSERT_NOW(a_count_bound, 1'b1, count_reg <= CNT_W'(DEPTH), "queue count overrun")
    `LTC_ASSERT_NEXT(a_rd_drops, do_rd && !do_wr, count_reg == $past(count_reg) - CNT_W'(1), "read lost")
    `LTC_ASSERT_NEXT(a_full_holds, full && !rd, full, "full queue drained without a read")

endmodule

// ===== hw/rtl/ltc_back.sv =====
// Back end: resolves a lexeme summary into a token class, output register.
// Depends on ltc_pkg.
module ltc_back
    import ltc_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    input  ltc_rec_t     in_rec,
    output logic         in_take,
    input  logic         pop,
    output logic         out_valid,
    output token_class_t token_class
);

    logic         out_valid_reg;
    token_class_t class_reg;
    token_class_t class_next;

    always_comb
    begin
        if (in_rec.quoted)
            class_next = in_rec.end_quote ? CLASS_LITERAL : CLASS_INVALID;
        else if (!in_rec.valid)
            class_next = CLASS_INVALID;
        else
        begin
            class_next = in_rec.digits ? CLASS_NUMBER : CLASS_IDENTIFIER;
            // lowest table index wins
            for (int k = TABLE_SIZE - 1; k >= 0; k--)
            begin
                if (in_rec.hit[k])
                    class_next = token_class_t'(k);
            end
        end
    end

    assign in_take     = in_valid && (!out_valid_reg || pop);
    assign out_valid   = out_valid_reg;
    assign token_class = class_reg;

    always_ff @(posedge clk)
    begin
        if (in_take)
            class_reg <= class_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (in_take)
            out_valid_reg <= 1'b1;
        else if (pop)
            out_valid_reg <= 1'b0;
    end

endmodule
